[rtl/b64_pkg.sv]
// Shared types, constants and the sextet-to-character map of the base64 encoder.
`default_nettype none
package b64_pkg;

	// Job queue depth between front and back.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] PAD_CHAR = 8'h3D; // '='

	// One job: what a single input beat turns into.
	typedef struct packed {
		logic [5:0] sx0;     // first sextet
		logic [5:0] sx1;     // second sextet, used when n_chars is 2
		logic [1:0] n_chars; // 1 or 2 alphabet chars
		logic [1:0] n_pads;  // 0, 1 or 2 '=' pads after them
		logic       fin;     // final char of the job ends the stream
	} job_t;

	localparam int JOB_W = $bits(job_t);

	// Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] c;
		if (s < 6'd26) begin
			c = 8'h41 + {2'b00, s};
		end else if (s < 6'd52) begin
			c = 8'h61 + {2'b00, s} - 8'd26;
		end else if (s < 6'd62) begin
			c = 8'h30 + {2'b00, s} - 8'd52;
		end else if (s == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/b64_front.sv]
// Front end: tracks group position and carry bits, turns each byte into a job.
`default_nettype none
module b64_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             acc,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output b64_pkg::job_t         job
);

	typedef enum logic [1:0] {PH_0, PH_1, PH_2} phase_t;

	phase_t     phase_q, phase_nx;
	logic [3:0] carry_q, carry_nx;

	always_comb begin
		job      = '0;
		phase_nx = PH_0;
		carry_nx = 4'd0;
		unique case (phase_q)
			PH_1: begin
				job.sx0 = {carry_q[1:0], data_byte[7:4]};
				if (last_byte) begin
					job.sx1     = {data_byte[3:0], 2'b00};
					job.n_chars = 2'd2;
					job.n_pads  = 2'd1;
					job.fin     = 1'b1;
				end else begin
					job.n_chars = 2'd1;
					phase_nx    = PH_2;
					carry_nx    = data_byte[3:0];
				end
			end
			PH_2: begin
				job.sx0     = {carry_q, data_byte[7:6]};
				job.sx1     = data_byte[5:0];
				job.n_chars = 2'd2;
				job.fin     = last_byte;
			end
			default: begin
				// group start (unused code 3 behaves the same)
				job.sx0 = data_byte[7:2];
				if (last_byte) begin
					job.sx1     = {data_byte[1:0], 4'b0000};
					job.n_chars = 2'd2;
					job.n_pads  = 2'd2;
					job.fin     = 1'b1;
				end else begin
					job.n_chars = 2'd1;
					phase_nx    = PH_1;
					carry_nx    = {2'b00, data_byte[1:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			carry_q <= 4'd0;
		end else if (acc) begin
			phase_q <= phase_nx;
			carry_q <= carry_nx;
		end
	end

endmodule
`default_nettype wire

[rtl/b64_queue.sv]
// Small job FIFO between the front end and the character sequencer.
`default_nettype none
module b64_queue #(
	parameter int DEPTH = b64_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire b64_pkg::job_t wr_job,
	output logic               full,
	input  wire logic          rd,
	output b64_pkg::job_t      rd_job,
	output logic               nempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64_pkg::job_t mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == CW'(DEPTH));
	assign nempty = (cnt_q != '0);
	assign rd_job = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!nempty |-> !rd) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

[rtl/b64_back.sv]
// Back end: steps through a job one character per cycle, while the output register is free or popped, into it.
`default_nettype none
module b64_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire b64_pkg::job_t q_job,
	input  wire logic          q_nempty,
	output logic               q_rd,
	input  wire logic          pop,
	output logic               empty,
	output logic [7:0]         char_out,
	output logic               last_char
);

	b64_pkg::job_t cur_q;
	logic          cur_vld_q;
	logic [1:0]    step_q;
	logic          out_vld_q;
	logic [7:0]    char_q;
	logic          last_q;

	logic [2:0] last_idx;
	logic       fin_step;
	logic       out_free;
	logic       emit;
	logic       take;
	logic [7:0] ch;
	logic       ch_last;

	assign last_idx = {1'b0, cur_q.n_chars} + {1'b0, cur_q.n_pads} - 3'd1;
	assign fin_step = ({1'b0, step_q} == last_idx);
	assign out_free = !out_vld_q || pop;
	assign emit     = cur_vld_q && out_free;
	assign take     = !cur_vld_q || (emit && fin_step);
	assign q_rd     = take && q_nempty;

	always_comb begin
		if ({1'b0, step_q} >= {1'b0, cur_q.n_chars}) begin
			ch = b64_pkg::PAD_CHAR;
		end else if (step_q == 2'd0) begin
			ch = b64_pkg::sextet_char(cur_q.sx0);
		end else begin
			ch = b64_pkg::sextet_char(cur_q.sx1);
		end
		ch_last = cur_q.fin && fin_step;
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_job;
		end
		if (emit) begin
			char_q <= ch;
			last_q <= ch_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			step_q    <= 2'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				cur_vld_q <= q_nempty;
				step_q    <= 2'd0;
			end else if (emit) begin
				step_q <= step_q + 2'd1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign empty     = !out_vld_q;
	assign char_out  = char_q;
	assign last_char = last_q;

	a_step_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q |-> ({1'b0, step_q} <= last_idx)) else $error("step past job end");
	a_job_shape: assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q |-> (cur_q.n_chars == 2'd1 && cur_q.n_pads == 2'd0 && !cur_q.fin)
			|| (cur_q.n_chars == 2'd2)) else $error("malformed job");
	a_no_emit_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !pop) |-> !emit) else $error("output overwritten");

endmodule
`default_nettype wire

[rtl/base64_stream_encoder.sv]
// Top level of the streaming base64 encoder: front end, job queue, character sequencer.
`default_nettype none
// Path: the first character of a byte passes the job queue, the job register and the result register.
// Throughput: one character per cycle at the result side while pop keeps the output register free;
// a byte makes 1 or 2 chars (3 or 4 with the end-of-stream pads); the rate is bound by the
// single-character output register. Input keeps flowing until the job queue fills.
// Reset: arst_n clears group position, carry bits, queue pointers and all valid flags at once.
module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input beats
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	// result beats
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      char_out,
	output logic            last_char
);

	b64_pkg::job_t fe_job;
	b64_pkg::job_t q_job;
	logic          acc;
	logic          q_rd;
	logic          q_nempty;

	// A beat is taken whenever the queue has room; the front end writes its job straight in.
	assign acc = push && !full;

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.job       (fe_job)
	);

	// Decouples the byte side from the character side so each can stall alone.
	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (acc),
		.wr_job (fe_job),
		.full   (full),
		.rd     (q_rd),
		.rd_job (q_job),
		.nempty (q_nempty)
	);

	// Emits the job's characters and pads, one per cycle while the result register is free or popped, through it.
	b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_job     (q_job),
		.q_nempty  (q_nempty),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.char_out  (char_out),
		.last_char (last_char)
	);

endmodule
`default_nettype wire

[bench/tb_base64_stream_encoder.sv]
// Self-checking bench for the streaming base64 encoder: queued byte driver, char monitor.
`timescale 1ns / 100ps

module tb_base64_stream_encoder;

	// Cycles with no beat on either side before the run is declared hung.
	// The longest legal quiet stretch is the receiver hold-off below.
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20; // well past the encoder latency
	localparam int ITEMS_PER_PHASE = 70;

	// Index 0 is 'A', index 63 is '/'; 'A' sits in the top byte.
	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// Position of the next byte inside its three-byte group.
	typedef enum logic [1:0] {
		GRP_FIRST,
		GRP_SECOND,
		GRP_THIRD
	} grp_pos_t;

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} byte_beat_t;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} char_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] char_out;
	logic       last_char;

	byte_beat_t pending_bytes[$];  // stimulus not yet accepted
	char_beat_t expected_chars[$]; // predicted chars not yet popped

	// Predictor state: mirrors the group position and the unsent low bits.
	grp_pos_t   group_pos = GRP_FIRST;
	logic [3:0] carry_nib = 4'h0;

	// Idle knobs, in percent of cycles; changed by the sequencer per phase.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Long receiver hold-off: requested by the sequencer, timed by the monitor.
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;

	int mismatches = 0;
	int quiet_cycles = 0;

	base64_stream_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.empty     (empty),
		.pop       (pop),
		.char_out  (char_out),
		.last_char (last_char)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [7:0] sextet_ascii(input logic [5:0] s);
		return ALPHABET[8*(63 - s) +: 8];
	endfunction

	function automatic void queue_char(input logic [7:0] ch, input logic fin);
		char_beat_t beat;
		beat.ch = ch;
		beat.fin = fin;
		expected_chars.push_back(beat);
	endfunction

	// Fold one accepted byte into the group and queue the chars it releases.
	// A marked byte flushes with zero fill, pads to four chars, and restarts the group.
	function automatic void encode_byte(input logic [7:0] b, input logic fin);
		case (group_pos)
			GRP_SECOND: begin
				// only the low two carry bits are live here
				queue_char(sextet_ascii({carry_nib[1:0], b[7:4]}), 1'b0);
				if (fin) begin
					queue_char(sextet_ascii({b[3:0], 2'b00}), 1'b0);
					queue_char(b64_pkg::PAD_CHAR, 1'b1);
					group_pos = GRP_FIRST;
					carry_nib = 4'h0;
				end else begin
					group_pos = GRP_THIRD;
					carry_nib = b[3:0];
				end
			end
			GRP_THIRD: begin
				// group complete: two chars, no padding even at the end
				queue_char(sextet_ascii({carry_nib, b[7:6]}), 1'b0);
				queue_char(sextet_ascii(b[5:0]), fin);
				group_pos = GRP_FIRST;
				carry_nib = 4'h0;
			end
			default: begin
				queue_char(sextet_ascii(b[7:2]), 1'b0);
				if (fin) begin
					queue_char(sextet_ascii({b[1:0], 4'h0}), 1'b0);
					queue_char(b64_pkg::PAD_CHAR, 1'b0);
					queue_char(b64_pkg::PAD_CHAR, 1'b1);
					group_pos = GRP_FIRST;
					carry_nib = 4'h0;
				end else begin
					group_pos = GRP_SECOND;
					carry_nib = {2'b00, b[1:0]};
				end
			end
		endcase
	endfunction

	function automatic void add_byte(input logic [7:0] data, input logic fin);
		byte_beat_t beat;
		beat.data = data;
		beat.fin = fin;
		pending_bytes.push_back(beat);
	endfunction

	// One random stream: mostly short, now and then long; bytes biased
	// a little toward all-zeros and all-ones.
	function automatic int add_stream();
		int len;
		int pick;
		logic [7:0] b;
		len = ($urandom_range(7) == 0) ? $urandom_range(30, 10) : $urandom_range(9, 1);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(15);
			b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
			add_byte(b, i == len - 1);
		end
		return len;
	endfunction

	// Driver: an offered beat goes through on an edge with push high and full low;
	// predict from what was on the bus, then offer the next queued byte or idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				encode_byte(data_byte, last_byte);
				void'(pending_bytes.pop_front());
			end
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				push <= 1'b1;
				data_byte <= pending_bytes[0].data;
				last_byte <= pending_bytes[0].fin;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: check each popped char against the oldest prediction, then
	// pick pop for the next cycle (random stall, or the long hold-off).
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected char: got %h last %b", $time, char_out, last_char);
					mismatches++;
				end else begin
					if (char_out !== expected_chars[0].ch) begin
						$display("%0t: char_out mismatch: expected %h got %h",
							$time, expected_chars[0].ch, char_out);
						mismatches++;
					end
					if (last_char !== expected_chars[0].fin) begin
						$display("%0t: last_char mismatch: expected %b got %b",
							$time, expected_chars[0].fin, last_char);
						mismatches++;
					end
					void'(expected_chars.pop_front());
				end
			end
			if (hold_req && !hold_taken) begin
				hold_left = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: any beat on either side restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_base64_stream_encoder NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Sequencer: reset, directed streams, then four idle phases of random streams.
	initial begin
		int send_pct[4];
		int recv_pct[4];
		int added;
		send_pct = '{0, 77, 0, 28};
		recv_pct = '{0, 0, 77, 28};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single-byte streams: the two-pad tail, zero and all-ones.
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		// Two-byte streams: the one-pad tail.
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b1);
		// Full groups ending the stream: no pads; "ABCD" and "+/+/".
		add_byte(8'h00, 1'b0);
		add_byte(8'h10, 1'b0);
		add_byte(8'h83, 1'b1);
		add_byte(8'hFB, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hBF, 1'b1);
		// "TWFuTWE=": one full group, then a partial one.
		add_byte(8'h4D, 1'b0);
		add_byte(8'h61, 1'b0);
		add_byte(8'h6E, 1'b0);
		add_byte(8'h4D, 1'b0);
		add_byte(8'h61, 1'b1);
		// Alternating bit patterns across a group boundary.
		add_byte(8'hA5, 1'b0);
		add_byte(8'h5A, 1'b0);
		add_byte(8'h3C, 1'b0);
		add_byte(8'hC3, 1'b1);
		while (pending_bytes.size() != 0) @(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			// First phase: sender never idles, so a long receiver hold-off
			// backs the block up until it drops push acceptance.
			if (ph == 0) begin
				hold_req = 1'b1;
			end
			added = 0;
			while (added < ITEMS_PER_PHASE) begin
				added += add_stream();
			end
			while (pending_bytes.size() != 0) @(posedge clk);
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (expected_chars.size() != 0) @(posedge clk);
		// Extra cycles catch any stray char after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("tb_base64_stream_encoder OK");
		end else begin
			$display("tb_base64_stream_encoder NOT OK");
		end
		$finish;
	end

endmodule
